/* hw/rtl/bhpq_pkg.sv */
// Shared types, constants and the order compare for the binary heap priority queue.
// Used by bhpq_front, bhpq_engine and binary_heap_priority_queue.
`timescale 1ns / 1ps

package bhpq_pkg;

  // Payload widths fixed by the stream format
  localparam int DATA_W       = 32;
  localparam int COUNT_OUT_W  = 7;
  localparam int TDATA_IN_W   = 32;
  localparam int TUSER_IN_W   = 1;
  localparam int TDATA_OUT_W  = 48;
  localparam int OUT_PAD_W    = TDATA_OUT_W - DATA_W - 2 - COUNT_OUT_W;

  // Default heap size
  localparam int CAPACITY_DEFAULT = 64;

  // Command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Requested operation
  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  // Decoded command handed from front to back
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_LOAD,
    S_DOWN,
    S_PLACE,
    S_DONE
  } state_t;

  // True when a belongs strictly above b; mode 0 is max-heap, mode 1 is min-heap
  function automatic logic outranks(input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b,
                                    input logic                     mode);
    logic res;
    begin
      if (mode) begin
        res = (a < b);
      end else begin
        res = (a > b);
      end
      return res;
    end
  endfunction

endpackage

/* hw/rtl/bhpq_front.sv */
// Front end: accepts input words, decodes the operation and queues commands.
// Depends on bhpq_pkg for cmd_t, op_t and the queue depth.
`timescale 1ns / 1ps

module bhpq_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bhpq_pkg::TDATA_IN_W-1:0]     s_axis_tdata,   // [31:0] value_in
  input  logic [bhpq_pkg::TUSER_IN_W-1:0]     s_axis_tuser,   // [0] func
  output logic                                cmd_valid,
  output bhpq_pkg::cmd_t                      cmd,
  input  logic                                cmd_pop
);

  localparam int DEPTH = bhpq_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  bhpq_pkg::cmd_t   queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;
  logic             push;
  logic             pop;
  bhpq_pkg::cmd_t   cmd_in;

  // Decode the incoming word into a command
  always_comb begin
    cmd_in.op    = s_axis_tuser[0] ? bhpq_pkg::OP_EXTRACT : bhpq_pkg::OP_INSERT;
    cmd_in.value = s_axis_tdata[bhpq_pkg::DATA_W-1:0];
  end

  assign s_axis_tready = (level != LVL_W'(DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = (level != '0);
  assign pop           = cmd_pop && cmd_valid;
  assign cmd           = queue[rd_ptr];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + LVL_W'(1);
        2'b01:   level <= level - LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

/* hw/rtl/bhpq_engine.sv */
// Back end: heap memory and the sequencer that runs sift-up and sift-down,
// plus the result register on the output stream. Depends on bhpq_pkg.
`timescale 1ns / 1ps

module bhpq_engine #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                order_mode,
  input  logic                                cmd_valid,
  input  bhpq_pkg::cmd_t                      cmd,
  output logic                                cmd_pop,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bhpq_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);

  localparam int DATA_W      = bhpq_pkg::DATA_W;
  localparam int COUNT_OUT_W = bhpq_pkg::COUNT_OUT_W;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CH_W        = CNT_W + 1;

  // Heap memory: one write port, two registered read ports
  logic signed [DATA_W-1:0] heap_mem [CAPACITY];
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;
  logic [IDX_W-1:0]         rd_addr_a;
  logic [IDX_W-1:0]         rd_addr_b;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;

  // Sequencer registers
  bhpq_pkg::state_t         state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         idx, idx_next;
  logic signed [DATA_W-1:0] hold, hold_next;
  logic signed [DATA_W-1:0] res_value, res_value_next;
  logic                     res_empty, res_empty_next;
  logic                     res_full, res_full_next;

  // Result register
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_empty;
  logic                     out_full;
  logic [COUNT_OUT_W-1:0]   out_count;
  logic                     out_load;

  // Sift helpers
  logic [IDX_W-1:0]         parent;
  logic [IDX_W-1:0]         count_parent;
  logic [CH_W-1:0]          child_l;
  logic [CH_W-1:0]          child_r;
  logic                     take_l;
  logic                     take_r;
  logic signed [DATA_W-1:0] best_val;
  logic [IDX_W-1:0]         move_idx;
  logic [CH_W-1:0]          move_l;
  logic [CH_W-1:0]          move_r;

  // Memory access
  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= heap_mem[rd_addr_a];
    rd_b <= heap_mem[rd_addr_b];
  end

  // Tree index arithmetic
  always_comb begin
    parent       = IDX_W'((idx - IDX_W'(1)) >> 1);
    count_parent = IDX_W'((count - CNT_W'(1)) >> 1);
    child_l      = CH_W'({idx, 1'b1});
    child_r      = child_l + CH_W'(1);
    take_l       = (child_l < CH_W'(count)) &&
                   bhpq_pkg::outranks(rd_a, hold, order_mode);
    best_val     = take_l ? rd_a : hold;
    take_r       = (child_r < CH_W'(count)) &&
                   bhpq_pkg::outranks(rd_b, best_val, order_mode);
    move_idx     = take_r ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];
    move_l       = CH_W'({move_idx, 1'b1});
    move_r       = move_l + CH_W'(1);
  end

  // Next state, memory controls and queue pop
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    hold_next      = hold;
    res_value_next = res_value;
    res_empty_next = res_empty;
    res_full_next  = res_full;
    mem_we         = 1'b0;
    mem_waddr      = idx;
    mem_wdata      = hold;
    rd_addr_a      = '0;
    rd_addr_b      = '0;
    cmd_pop        = 1'b0;
    out_load       = 1'b0;

    case (state)
      bhpq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          res_value_next = '0;
          res_empty_next = 1'b0;
          res_full_next  = 1'b0;
          if (cmd.op == bhpq_pkg::OP_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              res_full_next = 1'b1;
              state_next    = bhpq_pkg::S_DONE;
            end else if (count == '0) begin
              // First value goes straight to the root
              mem_we     = 1'b1;
              mem_waddr  = '0;
              mem_wdata  = cmd.value;
              count_next = count + CNT_W'(1);
              state_next = bhpq_pkg::S_DONE;
            end else begin
              hold_next  = cmd.value;
              idx_next   = count[IDX_W-1:0];
              count_next = count + CNT_W'(1);
              rd_addr_a  = count_parent;
              state_next = bhpq_pkg::S_UP;
            end
          end else begin
            if (count == '0) begin
              res_empty_next = 1'b1;
              state_next     = bhpq_pkg::S_DONE;
            end else begin
              // Fetch the root and the last element
              count_next = count - CNT_W'(1);
              rd_addr_a  = '0;
              rd_addr_b  = IDX_W'(count - CNT_W'(1));
              state_next = bhpq_pkg::S_LOAD;
            end
          end
        end
      end

      bhpq_pkg::S_UP: begin
        // rd_a holds the parent of the hole at idx
        if (bhpq_pkg::outranks(hold, rd_a, order_mode)) begin
          mem_we    = 1'b1;
          mem_waddr = idx;
          mem_wdata = rd_a;
          idx_next  = parent;
          if (parent == '0) begin
            state_next = bhpq_pkg::S_PLACE;
          end else begin
            rd_addr_a = IDX_W'((parent - IDX_W'(1)) >> 1);
          end
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = idx;
          mem_wdata  = hold;
          state_next = bhpq_pkg::S_DONE;
        end
      end

      bhpq_pkg::S_LOAD: begin
        res_value_next = rd_a;
        hold_next      = rd_b;
        idx_next       = '0;
        rd_addr_a      = IDX_W'(1);
        rd_addr_b      = IDX_W'(2);
        state_next     = bhpq_pkg::S_DOWN;
      end

      bhpq_pkg::S_DOWN: begin
        // rd_a / rd_b hold the left / right children of the hole at idx
        mem_we    = 1'b1;
        mem_waddr = idx;
        if (take_l || take_r) begin
          mem_wdata = take_r ? rd_b : rd_a;
          idx_next  = move_idx;
          rd_addr_a = move_l[IDX_W-1:0];
          rd_addr_b = move_r[IDX_W-1:0];
        end else begin
          mem_wdata  = hold;
          state_next = bhpq_pkg::S_DONE;
        end
      end

      bhpq_pkg::S_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = idx;
        mem_wdata  = hold;
        state_next = bhpq_pkg::S_DONE;
      end

      bhpq_pkg::S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = bhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bhpq_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhpq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    hold      <= hold_next;
    res_value <= res_value_next;
    res_empty <= res_empty_next;
    res_full  <= res_full_next;
  end

  // Output register: hold while stalled, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= res_value;
      out_empty <= res_empty;
      out_full  <= res_full;
      out_count <= COUNT_OUT_W'(count);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{bhpq_pkg::OUT_PAD_W{1'b0}}, out_count, out_full, out_empty,
                          out_value};

endmodule

/* hw/rtl/binary_heap_priority_queue.sv */
// Top level of the binary heap priority queue: order register, front end and back end.
// Depends on bhpq_pkg, bhpq_front and bhpq_engine.
`timescale 1ns / 1ps
//
// Usage:
//   Input stream s_axis: tdata carries the signed value to insert, tuser[0] the
//   operation (0 insert, 1 extract the root). Each word gives exactly one result
//   word on m_axis: extracted value, empty flag, full flag and the new count.
//   cfg_wr_en / cfg_wr_data write order_mode (0 largest at root, 1 smallest);
//   write it only while the queue is idle.
// Timing:
//   A word passes a two-entry command queue, then the sequencer runs it against
//   the heap memory, one tree level per cycle through a two-port registered read.
//   Insert sifts up from the end of the heap; extract fetches the root and the
//   last element and sifts down. One word is in the sequencer at a time: it takes
//   a new word only after it has handed the last result to the output register.
//   The output register loads a result as soon as it is free.
// Reset: rst empties the heap (count 0), clears order_mode and both streams.
// Stall: a stalled result is held in the output register and the next finished
//   word waits in the sequencer; the command queue takes up to two more words,
//   then s_axis_tready drops.
//
module binary_heap_priority_queue #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bhpq_pkg::TDATA_IN_W-1:0]     s_axis_tdata,   // [31:0] value_in
  input  logic [bhpq_pkg::TUSER_IN_W-1:0]     s_axis_tuser,   // [0] func
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] value_out, [32] empty_error, [33] full_error, [40:34] count_out, [47:41] zero
  output logic [bhpq_pkg::TDATA_OUT_W-1:0]    m_axis_tdata
);

  localparam int DATA_W      = bhpq_pkg::DATA_W;
  localparam int COUNT_OUT_W = bhpq_pkg::COUNT_OUT_W;
  localparam logic [COUNT_OUT_W-1:0] FULL_COUNT = COUNT_OUT_W'(CAPACITY);

  logic           order_mode;
  logic           cmd_valid;
  logic           cmd_pop;
  bhpq_pkg::cmd_t cmd;

  // Hold the order register
  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      order_mode <= cfg_wr_data;
    end
  end

  bhpq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  bhpq_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .order_mode    (order_mode),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // An error result never carries both flags
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[DATA_W] && m_axis_tdata[DATA_W+1]))
    else $error("result flags both empty and full");

  // An empty extract returns zero with count zero
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[DATA_W]) |->
      (m_axis_tdata[DATA_W-1:0] == '0 &&
       m_axis_tdata[DATA_W+2+COUNT_OUT_W-1:DATA_W+2] == '0))
    else $error("empty extract with nonzero value or count");

  // A dropped insert reports a full heap
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[DATA_W+1]) |->
      (m_axis_tdata[DATA_W+2+COUNT_OUT_W-1:DATA_W+2] == FULL_COUNT))
    else $error("full error with count below capacity");

  // Command queue is popped only when it holds a command
  assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

endmodule
